### rtl/core/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants of the RGB channel mixer.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int unsigned PIX_BITS  = 8;
  localparam int unsigned W_BITS    = 16;
  localparam int unsigned ROW_BITS  = 48;
  localparam int unsigned GAIN_BITS = 32;
  localparam int unsigned NUM_ROWS  = 4;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned CFG_BITS  = 3;

  typedef logic [PIX_BITS-1:0]  pix_t;
  typedef logic [W_BITS-1:0]    weight_t;
  // weight 0 is red, 1 is green, 2 is blue
  typedef weight_t [NUM_LANES-1:0] row_t;
  typedef logic [GAIN_BITS-1:0] gain_t;

  // row order in the row and gain arrays
  localparam logic [1:0] ROW_GRAY = 2'd0;

  localparam gain_t GAIN_ONE = 32'h0001_0000;

  localparam row_t GRAY_ROW_RST  = 48'h0000_0000_0000;
  localparam row_t RED_ROW_RST   = 48'h0000_0000_1000;
  localparam row_t GREEN_ROW_RST = 48'h0000_1000_0000;
  localparam row_t BLUE_ROW_RST  = 48'h1000_0000_0000;

  typedef enum logic [CFG_BITS-1:0] {
    CFG_MONO_MODE  = 3'd0,
    CFG_KEEP_LUMA  = 3'd1,
    CFG_GRAY_ROW   = 3'd2,
    CFG_RED_ROW    = 3'd3,
    CFG_GREEN_ROW  = 3'd4,
    CFG_BLUE_ROW   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                   mono;
    row_t  [NUM_ROWS-1:0]   rows;
    gain_t [NUM_ROWS-1:0]   gains;
  } mix_cfg_t;

endpackage

### rtl/core/rcm_gain_div.sv
// ----------------------------------------------------------------------------
// rcm_gain_div
// Row gain sequencer: restoring divider, one quotient bit per cycle, that
// sweeps the four rows after each write to a defined register and holds the gains.
// ----------------------------------------------------------------------------
module rcm_gain_div #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic                                       keep_i,
  input  rcm_pkg::row_t  [rcm_pkg::NUM_ROWS-1:0]     rows_i,
  output rcm_pkg::gain_t [rcm_pkg::NUM_ROWS-1:0]     gains_o,
  output logic                                       busy_o
);

  localparam int unsigned QW   = COEF_FRAC_BITS + 17;
  localparam int unsigned CW   = $clog2(QW);
  localparam int unsigned DIVW = 17;
  localparam int unsigned SUMW = 18;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_RUN  = 3'b100
  } div_state_e;

  div_state_e                             state_q, state_d;
  logic [1:0]                             row_idx_q, row_idx_d;
  logic [CW-1:0]                          bit_cnt_q, bit_cnt_d;
  logic [DIVW-1:0]                        rem_q, rem_d;
  logic [DIVW-1:0]                        div_q, div_d;
  logic [QW-1:0]                          quo_q, quo_d;
  rcm_pkg::gain_t [rcm_pkg::NUM_ROWS-1:0] gains_q, gains_d;

  rcm_pkg::row_t         sel_row;
  logic signed [SUMW-1:0] row_sum;
  logic [DIVW-1:0]       row_mag;
  logic [DIVW:0]         shifted;
  logic                  fits;
  logic [DIVW-1:0]       rem_nxt;
  logic [QW-1:0]         quo_fin;
  logic [63:0]           quo_wide;
  rcm_pkg::gain_t        gain_div;
  logic                  last_row;

  always_comb begin
    sel_row  = rows_i[row_idx_q];
    row_sum  = SUMW'($signed(sel_row[0])) + SUMW'($signed(sel_row[1]))
             + SUMW'($signed(sel_row[2]));
    row_mag  = row_sum[SUMW-1] ? DIVW'(-row_sum) : DIVW'(row_sum);
    shifted  = {rem_q, (bit_cnt_q == '0)};
    fits     = shifted >= {1'b0, div_q};
    rem_nxt  = fits ? DIVW'(shifted - {1'b0, div_q}) : DIVW'(shifted);
    quo_fin  = {quo_q[QW-2:0], fits};
    quo_wide = 64'(quo_fin);
    gain_div = (quo_wide > 64'h0000_0000_FFFF_FFFF) ? '1 : quo_wide[31:0];
    last_row = row_idx_q == 2'(rcm_pkg::NUM_ROWS - 1);
  end

  always_comb begin
    state_d   = state_q;
    row_idx_d = row_idx_q;
    bit_cnt_d = bit_cnt_q;
    rem_d     = rem_q;
    div_d     = div_q;
    quo_d     = quo_q;
    gains_d   = gains_q;
    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_LOAD: begin
        div_d     = row_mag;
        rem_d     = '0;
        quo_d     = '0;
        bit_cnt_d = '0;
        if (!keep_i || row_sum == '0) begin
          gains_d[row_idx_q] = rcm_pkg::GAIN_ONE;
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            row_idx_d = row_idx_q + 2'd1;
          end
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_d     = rem_nxt;
        quo_d     = quo_fin;
        bit_cnt_d = bit_cnt_q + CW'(1);
        if (bit_cnt_q == CW'(QW - 1)) begin
          gains_d[row_idx_q] = gain_div;
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            row_idx_d = row_idx_q + 2'd1;
            state_d   = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (start_i) begin
      state_d   = ST_LOAD;
      row_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_idx_q <= '0;
      gains_q   <= {rcm_pkg::NUM_ROWS{rcm_pkg::GAIN_ONE}};
    end else begin
      state_q   <= state_d;
      row_idx_q <= row_idx_d;
      gains_q   <= gains_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_cnt_q <= bit_cnt_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    quo_q     <= quo_d;
  end

  assign gains_o = gains_q;
  assign busy_o  = state_q != ST_IDLE;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (div_q != '0))
    else $error("divider running with zero divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (state_q == ST_LOAD) && (row_idx_q == '0))
    else $error("gain sweep did not restart at the first row");

endmodule

### rtl/core/rcm_mix_pipe.sv
// ----------------------------------------------------------------------------
// rcm_mix_pipe
// Five-stage mixing datapath: products, row sum, gain partial products,
// rounding add, clamp. Each stage holds its own valid bit.
// ----------------------------------------------------------------------------
module rcm_mix_pipe #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcm_pkg::mix_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rcm_pkg::pix_t     in_red_i,
  input  rcm_pkg::pix_t     in_green_i,
  input  rcm_pkg::pix_t     in_blue_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rcm_pkg::pix_t     out_red_o,
  output rcm_pkg::pix_t     out_green_o,
  output rcm_pkg::pix_t     out_blue_o
);

  localparam int unsigned NL     = rcm_pkg::NUM_LANES;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned ACC_W  = 26;
  localparam int unsigned PART_W = ACC_W + 17;
  localparam int unsigned T_W    = 60;
  localparam int unsigned SH     = COEF_FRAC_BITS + 16;
  localparam logic [T_W-1:0] ROUND = T_W'(1) << (COEF_FRAC_BITS + 15);

  logic [4:0] v_q, v_d, en;

  rcm_pkg::row_t  lane_row  [NL];
  rcm_pkg::gain_t lane_gain [NL];
  rcm_pkg::pix_t  pix       [NL];

  logic signed [PROD_W-1:0] p1_q [NL][NL];
  logic signed [PROD_W-1:0] p1_d [NL][NL];
  logic signed [ACC_W-1:0]  acc_q [NL];
  logic signed [ACC_W-1:0]  acc_d [NL];
  logic signed [PART_W-1:0] lo_q [NL];
  logic signed [PART_W-1:0] lo_d [NL];
  logic signed [PART_W-1:0] hi_q [NL];
  logic signed [PART_W-1:0] hi_d [NL];
  logic signed [T_W-1:0]    t_q [NL];
  logic signed [T_W-1:0]    t_d [NL];
  logic [T_W-1:0]           qv [NL];
  rcm_pkg::pix_t            out_q [NL];
  rcm_pkg::pix_t            out_d [NL];

  // stall chain, a stage moves when empty or when the next one moves
  always_comb begin
    en[4] = ~v_q[4] | out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < 5; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_comb begin
    pix[0] = in_red_i;
    pix[1] = in_green_i;
    pix[2] = in_blue_i;
    for (int l = 0; l < NL; l++) begin
      lane_row[l]  = cfg_i.mono ? cfg_i.rows[rcm_pkg::ROW_GRAY]
                                : cfg_i.rows[2'(l + 1)];
      lane_gain[l] = cfg_i.mono ? cfg_i.gains[rcm_pkg::ROW_GRAY]
                                : cfg_i.gains[2'(l + 1)];
    end
    for (int l = 0; l < NL; l++) begin
      for (int k = 0; k < NL; k++) begin
        p1_d[l][k] = PROD_W'($signed(lane_row[l][k]) * $signed({1'b0, pix[k]}));
      end
      acc_d[l] = ACC_W'(p1_q[l][0]) + ACC_W'(p1_q[l][1]) + ACC_W'(p1_q[l][2]);
      lo_d[l]  = PART_W'(acc_q[l] * $signed({1'b0, lane_gain[l][15:0]}));
      hi_d[l]  = PART_W'(acc_q[l] * $signed({1'b0, lane_gain[l][31:16]}));
      t_d[l]   = (T_W'(hi_q[l]) <<< 16) + T_W'(lo_q[l]) + $signed(ROUND);
      qv[l]    = t_q[l] >> SH;
      if (t_q[l][T_W-1]) begin
        out_d[l] = '0;
      end else if (|qv[l][T_W-1:8]) begin
        out_d[l] = '1;
      end else begin
        out_d[l] = qv[l][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q <= p1_d;
    end
    if (en[1]) begin
      acc_q <= acc_d;
    end
    if (en[2]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en[3]) begin
      t_q <= t_d;
    end
    if (en[4]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[4];
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !out_ready_i && v_q[3]) |=> (v_q[4] && v_q[3]))
    else $error("stalled item dropped from rounding stage");

endmodule

### rtl/core/rgb_channel_mixer_unit.sv
// ----------------------------------------------------------------------------
// rgb_channel_mixer_unit
// Throughput one pixel per cycle unless the output stalls or a gain sweep runs.
// A write to a defined register reruns the gain divider, input held off meanwhile;
// unit-gain rows are set directly, the other rows are divided.
// Reset: identity rows, gray row zero, modes off, all gains one; no sweep.
// ----------------------------------------------------------------------------
module rgb_channel_mixer_unit #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcm_pkg::CFG_BITS-1:0]    cfg_index_i,
  input  logic [rcm_pkg::ROW_BITS-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rcm_pkg::pix_t                   in_red_i,
  input  rcm_pkg::pix_t                   in_green_i,
  input  rcm_pkg::pix_t                   in_blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rcm_pkg::pix_t                   out_red_o,
  output rcm_pkg::pix_t                   out_green_o,
  output rcm_pkg::pix_t                   out_blue_o
);

  logic                                   mono_q;
  logic                                   keep_q;
  rcm_pkg::row_t [rcm_pkg::NUM_ROWS-1:0]  rows_q;
  rcm_pkg::gain_t [rcm_pkg::NUM_ROWS-1:0] gains;
  rcm_pkg::mix_cfg_t                      mix_cfg;
  logic                                   cfg_write;
  logic                                   start;
  logic                                   busy;
  logic                                   pipe_ready;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign start       = cfg_write & (cfg_index_i <= rcm_pkg::CFG_BLUE_ROW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q    <= 1'b0;
      keep_q    <= 1'b0;
      rows_q[0] <= rcm_pkg::GRAY_ROW_RST;
      rows_q[1] <= rcm_pkg::RED_ROW_RST;
      rows_q[2] <= rcm_pkg::GREEN_ROW_RST;
      rows_q[3] <= rcm_pkg::BLUE_ROW_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        rcm_pkg::CFG_MONO_MODE: mono_q    <= cfg_data_i[0];
        rcm_pkg::CFG_KEEP_LUMA: keep_q    <= cfg_data_i[0];
        rcm_pkg::CFG_GRAY_ROW:  rows_q[0] <= cfg_data_i;
        rcm_pkg::CFG_RED_ROW:   rows_q[1] <= cfg_data_i;
        rcm_pkg::CFG_GREEN_ROW: rows_q[2] <= cfg_data_i;
        rcm_pkg::CFG_BLUE_ROW:  rows_q[3] <= cfg_data_i;
        default: begin
          mono_q <= mono_q;
        end
      endcase
    end
  end

  rcm_gain_div #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_gain_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .keep_i  (keep_q),
    .rows_i  (rows_q),
    .gains_o (gains),
    .busy_o  (busy)
  );

  assign mix_cfg.mono  = mono_q;
  assign mix_cfg.rows  = rows_q;
  assign mix_cfg.gains = gains;

  rcm_mix_pipe #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mix_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (mix_cfg),
    .in_valid_i  (in_valid_i & ~busy),
    .in_ready_o  (pipe_ready),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

  assign in_ready_o = pipe_ready & ~busy;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("pixel request taken during gain sweep");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks rgb_channel_mixer_unit pixel by pixel. A directed table covers the
// reset rows, channel extremes, monochrome mode, negative and zero-sum rows
// and luminosity scaling. Random phases follow, each one rewriting a few
// registers once all pending results have drained, then streaming pixels.
// Both sides idle and stall at random. Every result is compared with a table
// value or an in-bench model of the rounded, clamped and gain-scaled mix.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FRAC_BITS    = 12;
  localparam int unsigned RANDOM_ITEMS = 1490;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  localparam logic [rcm_pkg::CFG_BITS-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [rcm_pkg::CFG_BITS-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [1:0] ROW_RED   = 2'd1;
  localparam logic [1:0] ROW_GREEN = 2'd2;
  localparam logic [1:0] ROW_BLUE  = 2'd3;

  typedef struct packed {
    rcm_pkg::pix_t red;
    rcm_pkg::pix_t green;
    rcm_pkg::pix_t blue;
  } rgb_t;

  typedef enum logic {
    STEP_PIX,
    STEP_REG
  } step_kind_e;

  typedef struct packed {
    step_kind_e                   kind;
    logic [rcm_pkg::CFG_BITS-1:0] idx;
    rcm_pkg::row_t                data;
    rgb_t                         px;
    logic                         typed;
    rgb_t                         want;
  } step_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [rcm_pkg::CFG_BITS-1:0] cfg_index_i;
  logic [rcm_pkg::ROW_BITS-1:0] cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  rcm_pkg::pix_t                in_red_i;
  rcm_pkg::pix_t                in_green_i;
  rcm_pkg::pix_t                in_blue_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  rcm_pkg::pix_t                out_red_o;
  rcm_pkg::pix_t                out_green_o;
  rcm_pkg::pix_t                out_blue_o;

  // model of the register file and the held gains
  logic           mix_mono;
  logic           mix_keep;
  rcm_pkg::row_t  mix_rows  [rcm_pkg::NUM_ROWS];
  rcm_pkg::gain_t mix_gains [rcm_pkg::NUM_ROWS];

  rgb_t        mixed_q [$];
  step_t       plan_q  [$];
  rgb_t        head_px;
  int          err_cnt    = 0;
  int          stall_left = 0;
  int unsigned cycle_cnt  = 0;
  bit          in_calm    = 1'b0;
  bit          out_calm   = 1'b0;

  rgb_channel_mixer_unit #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rcm_pkg::row_t pack_row(rcm_pkg::weight_t w_red,
                                             rcm_pkg::weight_t w_green,
                                             rcm_pkg::weight_t w_blue);
    rcm_pkg::row_t row;
    row[0] = w_red;
    row[1] = w_green;
    row[2] = w_blue;
    return row;
  endfunction

  function automatic rcm_pkg::pix_t mix_lane(logic [1:0] sel, rgb_t px);
    longint acc;
    longint t;
    acc = longint'($signed(mix_rows[sel][0])) * longint'(px.red)
        + longint'($signed(mix_rows[sel][1])) * longint'(px.green)
        + longint'($signed(mix_rows[sel][2])) * longint'(px.blue);
    t = acc * longint'(mix_gains[sel]) + (longint'(1) << (FRAC_BITS + 15));
    if (t < 0) return '0;
    t = t >>> (FRAC_BITS + 16);
    return (t > 255) ? 8'hFF : rcm_pkg::pix_t'(t);
  endfunction

  function automatic rgb_t mix_pixel(rgb_t px);
    rgb_t res;
    if (mix_mono) begin
      res.red   = mix_lane(rcm_pkg::ROW_GRAY, px);
      res.green = res.red;
      res.blue  = res.red;
    end else begin
      res.red   = mix_lane(ROW_RED, px);
      res.green = mix_lane(ROW_GREEN, px);
      res.blue  = mix_lane(ROW_BLUE, px);
    end
    return res;
  endfunction

  task automatic send_pixel(rgb_t px, logic typed, rgb_t want);
    int gap;
    cfg_valid_i <= 1'b0;
    in_valid_i  <= 1'b1;
    in_red_i    <= px.red;
    in_green_i  <= px.green;
    in_blue_i   <= px.blue;
    do @(posedge clk_i); while (!in_ready_o);
    mixed_q.push_back(typed ? want : mix_pixel(px));
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [rcm_pkg::CFG_BITS-1:0] idx, rcm_pkg::row_t data);
    int     gap;
    longint sum;
    longint quo;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rcm_pkg::CFG_MONO_MODE: mix_mono = data[0][0];
      rcm_pkg::CFG_KEEP_LUMA: mix_keep = data[0][0];
      rcm_pkg::CFG_GRAY_ROW:  mix_rows[rcm_pkg::ROW_GRAY] = data;
      rcm_pkg::CFG_RED_ROW:   mix_rows[ROW_RED]   = data;
      rcm_pkg::CFG_GREEN_ROW: mix_rows[ROW_GREEN] = data;
      rcm_pkg::CFG_BLUE_ROW:  mix_rows[ROW_BLUE]  = data;
      default: ;
    endcase
    // every known write reruns the divider on all rows
    if (idx <= rcm_pkg::CFG_BLUE_ROW) begin
      for (int k = 0; k < rcm_pkg::NUM_ROWS; k++) begin
        sum = longint'($signed(mix_rows[k][0])) + longint'($signed(mix_rows[k][1]))
            + longint'($signed(mix_rows[k][2]));
        if (!mix_keep || sum == 0) begin
          mix_gains[k] = rcm_pkg::GAIN_ONE;
        end else begin
          if (sum < 0) sum = -sum;
          quo = (longint'(1) << (FRAC_BITS + 16)) / sum;
          mix_gains[k] = (quo > 64'sh0000_0000_FFFF_FFFF) ? '1 : rcm_pkg::gain_t'(quo);
        end
      end
    end
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic idle_wait();
    in_valid_i <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_pix(rcm_pkg::pix_t r, rcm_pkg::pix_t g, rcm_pkg::pix_t b);
    step_t st;
    st       = '0;
    st.kind  = STEP_PIX;
    st.px    = '{r, g, b};
    plan_q.push_back(st);
  endtask

  task automatic add_pix_exp(rcm_pkg::pix_t r, rcm_pkg::pix_t g, rcm_pkg::pix_t b,
                             rcm_pkg::pix_t er, rcm_pkg::pix_t eg, rcm_pkg::pix_t eb);
    step_t st;
    st       = '0;
    st.kind  = STEP_PIX;
    st.px    = '{r, g, b};
    st.typed = 1'b1;
    st.want  = '{er, eg, eb};
    plan_q.push_back(st);
  endtask

  task automatic add_reg(logic [rcm_pkg::CFG_BITS-1:0] idx, rcm_pkg::row_t data);
    step_t st;
    st      = '0;
    st.kind = STEP_REG;
    st.idx  = idx;
    st.data = data;
    plan_q.push_back(st);
  endtask

  // output side stalls
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap(1'b0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mixed_q.size() == 0) begin
        $error("out: unexpected result %0d %0d %0d", out_red_o, out_green_o, out_blue_o);
        err_cnt++;
      end else begin
        head_px = mixed_q.pop_front();
        if (out_red_o !== head_px.red) begin
          $error("out_red: expected %0d, got %0d", head_px.red, out_red_o);
          err_cnt++;
        end
        if (out_green_o !== head_px.green) begin
          $error("out_green: expected %0d, got %0d", head_px.green, out_green_o);
          err_cnt++;
        end
        if (out_blue_o !== head_px.blue) begin
          $error("out_blue: expected %0d, got %0d", head_px.blue, out_blue_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int                           sent;
    int                           n_px;
    int                           n_writes;
    int                           style;
    step_t                        st;
    rgb_t                         px;
    logic [rcm_pkg::CFG_BITS-1:0] idx;
    rcm_pkg::row_t                wdata;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_red_i    <= '0;
    in_green_i  <= '0;
    in_blue_i   <= '0;
    out_ready_i <= 1'b0;

    mix_mono                    = 1'b0;
    mix_keep                    = 1'b0;
    mix_rows[rcm_pkg::ROW_GRAY] = rcm_pkg::GRAY_ROW_RST;
    mix_rows[ROW_RED]           = rcm_pkg::RED_ROW_RST;
    mix_rows[ROW_GREEN]         = rcm_pkg::GREEN_ROW_RST;
    mix_rows[ROW_BLUE]          = rcm_pkg::BLUE_ROW_RST;
    for (int k = 0; k < rcm_pkg::NUM_ROWS; k++) mix_gains[k] = rcm_pkg::GAIN_ONE;

    // identity after reset
    add_pix_exp(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_pix_exp(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pix_exp(8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56);
    add_pix_exp(8'hA5, 8'h5A, 8'hFF, 8'hA5, 8'h5A, 8'hFF);
    // mono with zero gray row
    add_reg(rcm_pkg::CFG_MONO_MODE, 48'h0000_0000_0001);
    add_pix_exp(8'd200, 8'd100, 8'd50, 8'h00, 8'h00, 8'h00);
    // luma weights summing to one
    add_reg(rcm_pkg::CFG_GRAY_ROW, pack_row(16'h04C9, 16'h0964, 16'h01D3));
    add_pix_exp(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pix(8'hFF, 8'h00, 8'h00);
    add_reg(rcm_pkg::CFG_KEEP_LUMA, 48'h0000_0000_0001);
    add_pix(8'd10, 8'd200, 8'd30);
    // negative row clamps to zero
    add_reg(rcm_pkg::CFG_GRAY_ROW, pack_row(16'hF000, 16'h0000, 16'h0000));
    add_pix_exp(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_pix_exp(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    // largest sum, smallest gain
    add_reg(rcm_pkg::CFG_GRAY_ROW, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    add_pix(8'hFF, 8'hFF, 8'hFF);
    // sum of one lsb, largest gain
    add_reg(rcm_pkg::CFG_GRAY_ROW, pack_row(16'h0001, 16'h0000, 16'h0000));
    add_pix(8'h01, 8'h00, 8'h00);
    add_pix(8'hFF, 8'hFF, 8'hFF);
    // zero sum keeps unity gain
    add_reg(rcm_pkg::CFG_GRAY_ROW, pack_row(16'h1000, 16'hF000, 16'h0000));
    add_pix_exp(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    add_pix_exp(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    // back to color, upper data bits ignored
    add_reg(rcm_pkg::CFG_MONO_MODE, 48'hFFFF_FFFF_FFFE);
    add_reg(rcm_pkg::CFG_RED_ROW, pack_row(16'h8000, 16'h8000, 16'h8000));
    add_reg(rcm_pkg::CFG_GREEN_ROW, pack_row(16'h7FFF, 16'h8000, 16'h0800));
    add_reg(rcm_pkg::CFG_BLUE_ROW, pack_row(16'h0555, 16'h0555, 16'h0556));
    add_pix(8'hFF, 8'hFF, 8'hFF);
    add_pix(8'h00, 8'h80, 8'hFF);
    // unused indexes
    add_reg(CFG_SPARE_A, 48'h5A5A_5A5A_5A5A);
    add_reg(CFG_SPARE_B, 48'hA5A5_A5A5_A5A5);
    add_pix(8'd77, 8'd150, 8'd29);
    add_reg(rcm_pkg::CFG_KEEP_LUMA, 48'hAAAA_AAAA_AAAA);
    add_pix(8'hFF, 8'h00, 8'hFF);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      st = plan_q[i];
      if (st.kind == STEP_REG) begin
        idle_wait();
        write_reg(st.idx, st.data);
      end else begin
        send_pixel(st.px, st.typed, st.want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_wait();
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      n_writes = $urandom_range(1, 4);
      repeat (n_writes) begin
        case ($urandom_range(0, 13))
          0, 1:    idx = rcm_pkg::CFG_MONO_MODE;
          2, 3:    idx = rcm_pkg::CFG_KEEP_LUMA;
          4, 5:    idx = rcm_pkg::CFG_GRAY_ROW;
          6, 7:    idx = rcm_pkg::CFG_RED_ROW;
          8, 9:    idx = rcm_pkg::CFG_GREEN_ROW;
          10, 11:  idx = rcm_pkg::CFG_BLUE_ROW;
          12:      idx = CFG_SPARE_A;
          default: idx = CFG_SPARE_B;
        endcase
        wdata = rcm_pkg::row_t'({$urandom(), $urandom()});
        if (idx >= rcm_pkg::CFG_GRAY_ROW && idx <= rcm_pkg::CFG_BLUE_ROW) begin
          style = $urandom_range(0, 9);
          for (int k = 0; k < rcm_pkg::NUM_LANES; k++) begin
            case (style)
              5:       wdata[k] = rcm_pkg::weight_t'($urandom());
              6: begin
                case ($urandom_range(0, 6))
                  0:       wdata[k] = 16'h8000;
                  1:       wdata[k] = 16'h7FFF;
                  2:       wdata[k] = 16'h0000;
                  3:       wdata[k] = 16'h1000;
                  4:       wdata[k] = 16'hF000;
                  5:       wdata[k] = 16'hFFFF;
                  default: wdata[k] = 16'h0001;
                endcase
              end
              7:       wdata[k] = rcm_pkg::weight_t'($urandom_range(0, 8191) - 4096);
              8, 9:    wdata[k] = rcm_pkg::weight_t'($urandom_range(0, 16) - 8);
              default: wdata[k] = rcm_pkg::weight_t'($urandom_range(0, 8191) - 2048);
            endcase
          end
          // zero-sum row
          if (style == 7) wdata[2] = -(wdata[0] + wdata[1]);
        end
        write_reg(idx, wdata);
      end
      n_px = $urandom_range(10, 80);
      repeat (n_px) begin
        px.red   = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                               : rcm_pkg::pix_t'($urandom_range(0, 255));
        px.green = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                               : rcm_pkg::pix_t'($urandom_range(0, 255));
        px.blue  = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                               : rcm_pkg::pix_t'($urandom_range(0, 255));
        send_pixel(px, 1'b0, '0);
      end
      sent += n_px;
    end

    idle_wait();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rcm_pkg.sv
rtl/core/rcm_gain_div.sv
rtl/core/rcm_mix_pipe.sv
rtl/core/rgb_channel_mixer_unit.sv
dv/testbench.sv
